// ----- src/lsgs_pkg.sv -----
`default_nettype none
package lsgs_pkg;

    // scan limits
    localparam int MAX_SAMPLES = 1024;
    localparam int SIZE_W      = 11;
    localparam int ANGLE_W     = 24;
    localparam int CFG_W       = 23;
    localparam int CFG_IDX_W   = 3;

    // steering arithmetic widths
    localparam int PROD_W = 41;
    localparam int NUM_W  = 42;
    localparam int MAG_W  = 41;
    localparam int LO_W   = 21;
    localparam int DVD_W  = 57;
    localparam int DVS_W  = 35;
    localparam int CNT_W  = 6;
    localparam logic [17:0] MILLI_SCALE = 18'd256000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ANGLE   = 3'd0,
        REG_ANGLE_STEP    = 3'd1,
        REG_END_ANGLE     = 3'd2,
        REG_RANGE_CEILING = 3'd3,
        REG_GAP_TOLERANCE = 3'd4,
        REG_SAFE_DISTANCE = 3'd5,
        REG_TOP_SPEED     = 3'd6,
        REG_TURN_GAIN     = 3'd7
    } cfg_reg_t;

    // configuration reset values
    localparam logic signed [22:0] START_ANGLE_RST = -23'sd2094395;
    localparam logic [16:0]        ANGLE_STEP_RST  = 17'd6136;
    localparam logic signed [22:0] END_ANGLE_RST   = 23'sd2094395;
    localparam logic [15:0]        CEILING_RST     = 16'd4000;
    localparam logic [15:0]        TOLERANCE_RST   = 16'd300;
    localparam logic [15:0]        SAFE_RST        = 16'd500;
    localparam logic [15:0]        TOP_SPEED_RST   = 16'd500;
    localparam logic [15:0]        TURN_GAIN_RST   = 16'd256;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_invalid;
        logic        last_sample;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        linear_speed;
        logic signed [15:0] steer_rate;
        logic [15:0]        nearest_range;
        logic [SIZE_W-1:0]  gap_samples;
        logic [15:0]        gap_top_range;
    } out_item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] rt;
        logic signed [ANGLE_W-1:0] lt;
        logic [15:0]               rd;
        logic [15:0]               ld;
        logic [15:0]               top;
        logic [SIZE_W-1:0]         size;
    } space_t;

    typedef enum logic [2:0] {
        S_SCAN,
        S_PROD,
        S_SUM,
        S_SCALE,
        S_LOAD,
        S_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic prod;
        logic sum;
        logic scale;
        logic load_div;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } stat_t;

    // candidate space replaces the best one
    function automatic logic space_wins(space_t cand, space_t best, logic best_valid);
        space_wins = !best_valid || (cand.top > best.top) ||
                     ((cand.top == best.top) && (cand.size > best.size));
    endfunction

endpackage
`default_nettype wire

// ----- src/lsgs_ctrl.sv -----
`default_nettype none
module lsgs_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    input  wire lsgs_pkg::stat_t  stat,
    output lsgs_pkg::cmd_t        cmd,
    output logic                  in_stall
);
    import lsgs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SCAN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                if (in_valid && in_last)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:   state_next = S_SUM;
            S_SUM:    state_next = S_SCALE;
            S_SCALE:  state_next = S_LOAD;
            S_LOAD:   state_next = S_DIV;
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_SCAN;
                end
            end
            default:  state_next = S_SCAN;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_SCAN:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            S_PROD:   cmd.prod = 1'b1;
            S_SUM:    cmd.sum = 1'b1;
            S_SCALE:  cmd.scale = 1'b1;
            S_LOAD:   cmd.load_div = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_FINISH: cmd.load_out = stat.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/lsgs_datapath.sv -----
`default_nettype none
module lsgs_datapath
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [lsgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsgs_pkg::CFG_W-1:0]     cfg_data,
    input  wire lsgs_pkg::in_item_t             in_data,
    input  wire lsgs_pkg::cmd_t                 cmd,
    input  wire logic                           out_stall,
    output lsgs_pkg::stat_t                     stat,
    output logic                                out_valid,
    output lsgs_pkg::out_item_t                 out_data
);
    import lsgs_pkg::*;

    // configuration registers
    logic signed [22:0] start_angle_reg;
    logic [16:0]        angle_step_reg;
    logic signed [22:0] end_angle_reg;
    logic [15:0]        ceiling_reg;
    logic [15:0]        tolerance_reg;
    logic [15:0]        safe_reg;
    logic [15:0]        top_speed_reg;
    logic [15:0]        turn_gain_reg;

    // scan state
    logic [1:0]                phase_reg;
    logic [16:0]               held_reg;
    logic [15:0]               prev_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [15:0]               closest_reg;
    space_t                    open_reg;
    space_t                    best_reg;
    logic                      best_valid_reg;

    // captured scan result
    logic [15:0]  res_lin_reg;
    logic [15:0]  res_near_reg;
    space_t       res_space_reg;

    // steering arithmetic
    logic signed [PROD_W-1:0] p_left_reg;
    logic signed [PROD_W-1:0] p_right_reg;
    logic [16:0]              den_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [LO_W+15:0]         part_lo_reg;
    logic [MAG_W-LO_W+15:0]   part_hi_reg;
    logic [DVS_W-1:0]         dvs_reg;
    logic [DVS_W-1:0]         rem_reg;
    logic [DVD_W-1:0]         quo_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // per-sample combinational values
    logic [15:0]               c0;
    logic [16:0]               avg_sum;
    logic [15:0]               diff;
    logic [15:0]               closest_a;
    logic signed [ANGLE_W:0]   angle_sum;
    logic signed [ANGLE_W-1:0] angle_a;
    logic signed [ANGLE_W-1:0] start_s;
    logic signed [ANGLE_W-1:0] end_s;
    space_t                    open_a;
    space_t                    best_a;
    logic                      best_valid_a;
    space_t                    cand;
    space_t                    fin;
    space_t                    best_f;
    logic [15:0]               c_last;
    logic [15:0]               lin;

    // division step and steering saturation
    logic [DVS_W:0]           trial;
    logic                     trial_ge;
    logic signed [NUM_W-1:0]  num_sum;
    logic [DVD_W-1:0]         dividend;
    logic signed [15:0]       steer;

    // sample fill, space split and best space selection
    always_comb
    begin
        start_s  = ANGLE_W'(start_angle_reg);
        end_s    = ANGLE_W'(end_angle_reg);
        avg_sum  = {1'b0, in_data.range_mm} + {1'b0, prev_reg};
        case (phase_reg)
            2'd0:    c0 = in_data.range_invalid ? ceiling_reg : in_data.range_mm;
            2'd1:    c0 = !held_reg[16] ? held_reg[15:0] :
                          (!in_data.range_invalid ? in_data.range_mm : ceiling_reg);
            default: c0 = !held_reg[16] ? held_reg[15:0] :
                          (!in_data.range_invalid ? avg_sum[16:1] : ceiling_reg);
        endcase
        closest_a = (c0 < closest_reg) ? c0 : closest_reg;
        diff      = (c0 > prev_reg) ? (c0 - prev_reg) : (prev_reg - c0);
        angle_sum = {angle_reg[ANGLE_W-1], angle_reg} + $signed({8'd0, angle_step_reg});
        if (angle_sum > $signed({2'b00, {(ANGLE_W-1){1'b1}}}))
        begin
            angle_a = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
        else
        begin
            angle_a = angle_sum[ANGLE_W-1:0];
        end

        open_a       = open_reg;
        best_a       = best_reg;
        best_valid_a = best_valid_reg;
        cand         = open_reg;
        cand.lt      = angle_a;
        cand.ld      = c0;
        if (phase_reg != 2'd2)
        begin
            angle_a     = start_s;
            open_a      = '0;
            open_a.rt   = start_s;
            open_a.rd   = c0;
            open_a.top  = c0;
            open_a.size = SIZE_W'(1);
        end
        else if (diff < tolerance_reg)
        begin
            if (open_reg.size < SIZE_W'(MAX_SAMPLES))
            begin
                open_a.size = open_reg.size + SIZE_W'(1);
            end
            if (c0 > open_reg.top)
            begin
                open_a.top = c0;
            end
        end
        else
        begin
            if (space_wins(cand, best_reg, best_valid_reg))
            begin
                best_a       = cand;
                best_valid_a = 1'b1;
            end
            open_a      = '0;
            open_a.rt   = angle_reg;
            open_a.rd   = prev_reg;
            open_a.top  = c0;
            open_a.size = SIZE_W'(1);
        end

        c_last = ((phase_reg == 2'd0) || in_data.range_invalid) ? c0 : in_data.range_mm;
        fin    = open_a;
        fin.lt = end_s;
        fin.ld = c_last;
        best_f = space_wins(fin, best_a, best_valid_a) ? fin : best_a;

        lin = (closest_a > safe_reg) ? (closest_a - safe_reg) : 16'd0;
        if (lin > top_speed_reg)
        begin
            lin = top_speed_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= START_ANGLE_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
            end_angle_reg   <= END_ANGLE_RST;
            ceiling_reg     <= CEILING_RST;
            tolerance_reg   <= TOLERANCE_RST;
            safe_reg        <= SAFE_RST;
            top_speed_reg   <= TOP_SPEED_RST;
            turn_gain_reg   <= TURN_GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_ANGLE:   start_angle_reg <= cfg_data;
                REG_ANGLE_STEP:    angle_step_reg  <= cfg_data[16:0];
                REG_END_ANGLE:     end_angle_reg   <= cfg_data;
                REG_RANGE_CEILING: ceiling_reg     <= cfg_data[15:0];
                REG_GAP_TOLERANCE: tolerance_reg   <= cfg_data[15:0];
                REG_SAFE_DISTANCE: safe_reg        <= cfg_data[15:0];
                REG_TOP_SPEED:     top_speed_reg   <= cfg_data[15:0];
                REG_TURN_GAIN:     turn_gain_reg   <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // scan state update per sample transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 2'd0;
            held_reg       <= '0;
            prev_reg       <= '0;
            angle_reg      <= '0;
            closest_reg    <= '1;
            open_reg       <= '0;
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (in_data.last_sample)
            begin
                phase_reg      <= 2'd0;
                held_reg       <= '0;
                prev_reg       <= '0;
                angle_reg      <= '0;
                closest_reg    <= '1;
                open_reg       <= '0;
                best_reg       <= '0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                held_reg <= {in_data.range_invalid, in_data.range_mm};
                if (phase_reg == 2'd0)
                begin
                    phase_reg <= 2'd1;
                end
                else
                begin
                    phase_reg      <= 2'd2;
                    prev_reg       <= c0;
                    angle_reg      <= angle_a;
                    closest_reg    <= closest_a;
                    open_reg       <= open_a;
                    best_reg       <= best_a;
                    best_valid_reg <= best_valid_a;
                end
            end
        end
    end

    // captured result and steering pipeline
    assign num_sum  = NUM_W'(p_left_reg) + NUM_W'(p_right_reg);
    assign dividend = {part_hi_reg, {LO_W{1'b0}}} + DVD_W'(part_lo_reg);
    assign trial    = {rem_reg, quo_reg[DVD_W-1]} - {1'b0, dvs_reg};
    assign trial_ge = {rem_reg, quo_reg[DVD_W-1]} >= {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.take && in_data.last_sample)
        begin
            res_lin_reg   <= lin;
            res_near_reg  <= closest_a;
            res_space_reg <= best_f;
        end
        if (cmd.prod)
        begin
            p_left_reg  <= res_space_reg.lt * $signed({1'b0, res_space_reg.ld});
            p_right_reg <= res_space_reg.rt * $signed({1'b0, res_space_reg.rd});
            den_reg     <= {1'b0, res_space_reg.ld} + {1'b0, res_space_reg.rd};
        end
        if (cmd.sum)
        begin
            neg_reg <= num_sum[NUM_W-1];
            mag_reg <= num_sum[NUM_W-1] ? MAG_W'(-num_sum) : MAG_W'(num_sum);
        end
        if (cmd.scale)
        begin
            part_lo_reg <= mag_reg[LO_W-1:0] * turn_gain_reg;
            part_hi_reg <= mag_reg[MAG_W-1:LO_W] * turn_gain_reg;
            dvs_reg     <= den_reg * MILLI_SCALE;
        end
        if (cmd.load_div)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial[DVS_W-1:0] : {rem_reg[DVS_W-2:0], quo_reg[DVD_W-1]};
            quo_reg <= {quo_reg[DVD_W-2:0], trial_ge};
        end
    end

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load_div)
        begin
            cnt_reg <= CNT_W'(DVD_W);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // quotient sign and saturation
    always_comb
    begin
        if (den_reg == 17'd0)
        begin
            steer = 16'sd0;
        end
        else if (!neg_reg)
        begin
            steer = (quo_reg > DVD_W'(32767)) ? 16'sh7FFF : $signed(quo_reg[15:0]);
        end
        else
        begin
            steer = (quo_reg > DVD_W'(32768)) ? 16'sh8000 : $signed(~quo_reg[15:0] + 16'd1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.linear_speed  <= res_lin_reg;
            out_data_reg.steer_rate    <= steer;
            out_data_reg.nearest_range <= res_near_reg;
            out_data_reg.gap_samples   <= res_space_reg.size;
            out_data_reg.gap_top_range <= res_space_reg.top;
        end
    end

    assign stat.div_last = (cnt_reg == CNT_W'(1));
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule
`default_nettype wire

// ----- src/laser_scan_gap_steering.sv -----
`default_nettype none
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_item_t: range_mm, range_invalid, last_sample
// out      output     out_valid/out_stall out_item_t: speed, steer, nearest, gap fields
// cfg      input      cfg_write          cfg_index selects register, cfg_data value
//
// one sample transaction per cycle while a scan is running
// the transaction with last_sample set is followed by four steps of
// products and scaling, then 57 steps of the bit-serial steering divider
// in_stall is high from the last sample until the result is in the output register
// a result waiting on out_stall does not block the next scan
// rst_n clears scan state, the controller and the output valid flag, and reloads config defaults
module laser_scan_gap_steering
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire lsgs_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output lsgs_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_write,
    input  wire logic [lsgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsgs_pkg::CFG_W-1:0]     cfg_data
);
    import lsgs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    lsgs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_sample),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // scan tracking and steering arithmetic
    lsgs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
